FILE: hdl/p2pd_pkg.sv
// Shared constants, codes and types for the message deframer.
`timescale 1ns / 1ps
`default_nettype none

package p2pd_pkg;

    localparam int HDR_LEN     = 24;
    localparam int MAGIC_OFS   = 0;
    localparam int CMD_OFS     = 4;
    localparam int CMD_HI_OFS  = 12;
    localparam int SIZE_OFS    = 16;
    localparam int CSUM_OFS    = 20;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } kind_t;

    // One classified input byte: an optional header or payload result,
    // optionally followed by a truncation error.
    typedef struct packed {
        logic        has_main;
        logic        main_header;
        logic        main_last;
        logic        trunc;
        logic [7:0]  payload_byte;
        logic [31:0] magic;
        logic [63:0] command_low;
        logic [31:0] command_high;
        logic [31:0] payload_size;
        logic [31:0] checksum;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/p2pd_in_if.sv
// Input byte channel of the message deframer.
`timescale 1ns / 1ps
`default_nettype none

interface p2pd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

FILE: hdl/p2pd_out_if.sv
// Result channel of the message deframer.
`timescale 1ns / 1ps
`default_nettype none

interface p2pd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] magic;
    logic [63:0] command_low;
    logic [31:0] command_high;
    logic [31:0] payload_size;
    logic [31:0] checksum;
    logic [7:0]  payload_byte;
    logic        last_of_message;

    modport source (
        output valid, output kind, output magic, output command_low,
        output command_high, output payload_size, output checksum,
        output payload_byte, output last_of_message, input ready
    );
    modport sink (
        input valid, input kind, input magic, input command_low,
        input command_high, input payload_size, input checksum,
        input payload_byte, input last_of_message, output ready
    );
endinterface

`default_nettype wire

FILE: hdl/p2p_message_deframer.sv
// Top level of the message deframer: front end, item queue and back end.
//
// in_stream carries one received byte per item, with end_of_buffer on the
// final byte of a buffer. out_stream carries results: a header result once
// the 24th header byte arrives, one result per payload byte, and a
// truncation error when a buffer ends inside a header or payload.
// Both channels move an item when valid and ready are high at a clock edge.
// Throughput: one input byte per cycle while the queue has room. A byte that
// completes a header of nonzero size, or carries a payload byte other than
// the last, and also ends the buffer yields two results, which leave the
// output one after the other. A result is written into the queue at the
// input edge and then loaded into the output register once that is free.
// When the receiver stalls, the output register holds its result, the queue
// of QUEUE_DEPTH items fills, and in_stream.ready drops once it is full.
// Reset clears the header count, payload count, queue and output valid; the
// block then expects the first byte of a header.
`timescale 1ns / 1ps
`default_nettype none

module p2p_message_deframer #(
    parameter int QUEUE_DEPTH = p2pd_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    p2pd_in_if.sink    in_stream,
    p2pd_out_if.source out_stream
);

    logic             push_valid;
    logic             push_ready;
    p2pd_pkg::entry_t push_entry;
    logic             head_valid;
    logic             pop;
    p2pd_pkg::entry_t head_entry;

    p2pd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    p2pd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    p2pd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule

`default_nettype wire

FILE: hdl/p2pd_front.sv
// Front end: takes bytes, gathers headers, counts payload, classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module p2pd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    p2pd_in_if.sink              in_stream,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output p2pd_pkg::entry_t     push_entry
);

    localparam int CNT_W = $clog2(p2pd_pkg::HDR_LEN);

    logic                 in_payload_reg;
    logic                 in_payload_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [31:0]          left_reg;
    logic [31:0]          left_next;
    logic [7:0]           hdr_reg [p2pd_pkg::HDR_LEN-1];
    logic [8*p2pd_pkg::HDR_LEN-1:0] hdr_vec;
    logic [31:0]          size;
    logic                 hdr_done;
    logic                 accept;
    p2pd_pkg::entry_t     entry;

    assign in_stream.ready = push_ready;
    assign accept          = in_stream.valid && push_ready;

    // Last header byte comes straight from the input.
    always_comb
    begin
        for (int i = 0; i < p2pd_pkg::HDR_LEN - 1; i++)
        begin
            hdr_vec[8*i +: 8] = hdr_reg[i];
        end
        hdr_vec[8*(p2pd_pkg::HDR_LEN-1) +: 8] = in_stream.data_byte;
    end

    assign size     = hdr_vec[8*p2pd_pkg::SIZE_OFS +: 32];
    assign hdr_done = !in_payload_reg && (cnt_reg == CNT_W'(p2pd_pkg::HDR_LEN - 1));

    always_comb
    begin
        entry           = '0;
        in_payload_next = in_payload_reg;
        cnt_next        = cnt_reg;
        left_next       = left_reg;
        if (in_payload_reg)
        begin
            entry.has_main     = 1'b1;
            entry.payload_byte = in_stream.data_byte;
            left_next          = left_reg - 32'd1;
            if (left_reg == 32'd1)
            begin
                entry.main_last = 1'b1;
                in_payload_next = 1'b0;
            end
        end
        else if (hdr_done)
        begin
            entry.has_main     = 1'b1;
            entry.main_header  = 1'b1;
            entry.magic        = hdr_vec[8*p2pd_pkg::MAGIC_OFS +: 32];
            entry.command_low  = hdr_vec[8*p2pd_pkg::CMD_OFS +: 64];
            entry.command_high = hdr_vec[8*p2pd_pkg::CMD_HI_OFS +: 32];
            entry.payload_size = size;
            entry.checksum     = hdr_vec[8*p2pd_pkg::CSUM_OFS +: 32];
            cnt_next           = '0;
            left_next          = size;
            if (size == 32'd0)
            begin
                entry.main_last = 1'b1;
            end
            else
            begin
                in_payload_next = 1'b1;
            end
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (in_stream.end_of_buffer && (in_payload_next || cnt_next != '0))
        begin
            entry.trunc     = 1'b1;
            in_payload_next = 1'b0;
            cnt_next        = '0;
            left_next       = '0;
        end
    end

    assign push_entry = entry;
    assign push_valid = in_stream.valid && (entry.has_main || entry.trunc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            cnt_reg        <= '0;
            left_reg       <= '0;
        end
        else if (accept)
        begin
            in_payload_reg <= in_payload_next;
            cnt_reg        <= cnt_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_payload_reg && (cnt_reg < CNT_W'(p2pd_pkg::HDR_LEN - 1)))
        begin
            hdr_reg[cnt_reg] <= in_stream.data_byte;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/p2pd_queue.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module p2pd_queue #(
    parameter int DEPTH = p2pd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire p2pd_pkg::entry_t push_entry,
    output logic                  head_valid,
    input  wire logic             pop,
    output p2pd_pkg::entry_t      head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    p2pd_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/p2pd_back.sv
// Back end: expands queued items into results and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module p2pd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire p2pd_pkg::entry_t head_entry,
    output logic                  pop,
    p2pd_out_if.source            out_stream
);

    logic                 phase_reg;
    logic                 phase_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 show_main;
    logic                 load;
    p2pd_pkg::kind_t      kind_next;
    p2pd_pkg::kind_t      kind_reg;
    logic [31:0]          magic_reg;
    logic [63:0]          command_low_reg;
    logic [31:0]          command_high_reg;
    logic [31:0]          payload_size_reg;
    logic [31:0]          checksum_reg;
    logic [7:0]           payload_byte_reg;
    logic                 last_reg;

    // phase_reg set: main result of the head item is out, its truncation is next.
    assign show_main = head_entry.has_main && !phase_reg;
    assign load      = head_valid && (!out_valid_reg || out_stream.ready);
    assign pop       = load && !(show_main && head_entry.trunc);

    always_comb
    begin
        if (!show_main)
        begin
            kind_next = p2pd_pkg::KIND_TRUNC;
        end
        else if (head_entry.main_header)
        begin
            kind_next = p2pd_pkg::KIND_HEADER;
        end
        else
        begin
            kind_next = p2pd_pkg::KIND_PAYLOAD;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            phase_next     = show_main && head_entry.trunc;
            out_valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            if (show_main)
            begin
                magic_reg        <= head_entry.magic;
                command_low_reg  <= head_entry.command_low;
                command_high_reg <= head_entry.command_high;
                payload_size_reg <= head_entry.payload_size;
                checksum_reg     <= head_entry.checksum;
                payload_byte_reg <= head_entry.payload_byte;
                last_reg         <= head_entry.main_last;
            end
            else
            begin
                magic_reg        <= '0;
                command_low_reg  <= '0;
                command_high_reg <= '0;
                payload_size_reg <= '0;
                checksum_reg     <= '0;
                payload_byte_reg <= '0;
                last_reg         <= 1'b1;
            end
        end
    end

    assign out_stream.valid           = out_valid_reg;
    assign out_stream.kind            = kind_reg;
    assign out_stream.magic           = magic_reg;
    assign out_stream.command_low     = command_low_reg;
    assign out_stream.command_high    = command_high_reg;
    assign out_stream.payload_size    = payload_size_reg;
    assign out_stream.checksum        = checksum_reg;
    assign out_stream.payload_byte    = payload_byte_reg;
    assign out_stream.last_of_message = last_reg;

endmodule

`default_nettype wire

FILE: hdl/p2pd_checker.sv
// Port-level checks of the message deframer results, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module p2pd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [31:0] magic,
    input wire logic [63:0] command_low,
    input wire logic [31:0] payload_size,
    input wire logic [7:0]  payload_byte,
    input wire logic        last_of_message
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte))
        else $error("result changed while stalled");

    a_trunc_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == p2pd_pkg::KIND_TRUNC |->
            last_of_message && magic == '0 && payload_size == '0 && payload_byte == '0)
        else $error("truncation result with stray fields");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == p2pd_pkg::KIND_PAYLOAD |->
            magic == '0 && command_low == '0 && payload_size == '0)
        else $error("payload result with header fields");

    a_empty_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == p2pd_pkg::KIND_HEADER |->
            payload_byte == '0 && (last_of_message == (payload_size == '0)))
        else $error("header result last flag does not match size");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == p2pd_pkg::KIND_HEADER || kind == p2pd_pkg::KIND_PAYLOAD
            || kind == p2pd_pkg::KIND_TRUNC)
        else $error("undefined result kind");

endmodule

bind p2p_message_deframer p2pd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_stream.valid),
    .out_ready       (out_stream.ready),
    .kind            (out_stream.kind),
    .magic           (out_stream.magic),
    .command_low     (out_stream.command_low),
    .payload_size    (out_stream.payload_size),
    .payload_byte    (out_stream.payload_byte),
    .last_of_message (out_stream.last_of_message)
);

`default_nettype wire

FILE: bench/tb_p2p_message_deframer.sv
// Self-checking testbench for p2p_message_deframer: directed table and random messages.
`timescale 1ns / 1ps

module tb_p2p_message_deframer;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 64;
    localparam int PAUSE_AT     = 300;

    typedef struct packed {
        p2pd_pkg::kind_t kind;
        logic [31:0]     magic;
        logic [63:0]     command_low;
        logic [31:0]     command_high;
        logic [31:0]     payload_size;
        logic [31:0]     checksum;
        logic [7:0]      payload_byte;
        logic            last_of_message;
    } frame_result_t;

    // what a directed row must produce: the predictor's results, nothing, or one truncation
    typedef enum logic [1:0] {
        EXP_MODEL = 2'd0,
        EXP_NONE  = 2'd1,
        EXP_TRUNC = 2'd2
    } row_check_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        row_check_t check;
    } byte_row_t;

    // stray byte ending a buffer, then a zero-size header of extreme bytes ending the next
    localparam byte_row_t DIRECTED_ROWS [25] = '{
        '{8'hA5, 1'b1, EXP_TRUNC},
        '{8'hFF, 1'b0, EXP_NONE}, '{8'hFF, 1'b0, EXP_NONE},
        '{8'hFF, 1'b0, EXP_NONE}, '{8'hFF, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'hFF, 1'b0, EXP_NONE}, '{8'hFF, 1'b0, EXP_NONE},
        '{8'hFF, 1'b0, EXP_NONE}, '{8'hFF, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE}, '{8'h00, 1'b0, EXP_NONE},
        '{8'h80, 1'b0, EXP_NONE}, '{8'h7F, 1'b0, EXP_NONE},
        '{8'h01, 1'b0, EXP_NONE}, '{8'hFE, 1'b1, EXP_MODEL}
    };

    logic clk = 1'b0;
    logic rst_n;

    p2pd_in_if  in_if ();
    p2pd_out_if out_if ();

    p2p_message_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    always #5 clk = ~clk;

    // predictor state
    logic        frame_in_payload;
    logic [4:0]  hdr_fill;
    logic [7:0]  hdr_buf [p2pd_pkg::HDR_LEN];
    logic [31:0] bytes_left;

    frame_result_t pending_results [$];
    int errors      = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    function automatic logic [31:0] hdr_word(input int ofs);
        return {hdr_buf[ofs + 3], hdr_buf[ofs + 2], hdr_buf[ofs + 1], hdr_buf[ofs]};
    endfunction

    function automatic frame_result_t trunc_result();
        frame_result_t r;
        r = '0;
        r.kind = p2pd_pkg::KIND_TRUNC;
        r.last_of_message = 1'b1;
        return r;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic eob);
        frame_result_t r;
        r = '0;
        if (frame_in_payload)
        begin
            r.kind = p2pd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'd0)
            begin
                frame_in_payload = 1'b0;
                r.last_of_message = 1'b1;
            end
            pending_results.push_back(r);
        end
        else
        begin
            hdr_buf[hdr_fill] = b;
            hdr_fill = hdr_fill + 5'd1;
            if (hdr_fill == p2pd_pkg::HDR_LEN)
            begin
                r.kind = p2pd_pkg::KIND_HEADER;
                r.magic = hdr_word(p2pd_pkg::MAGIC_OFS);
                r.command_low = {hdr_word(p2pd_pkg::CMD_OFS + 4), hdr_word(p2pd_pkg::CMD_OFS)};
                r.command_high = hdr_word(p2pd_pkg::CMD_HI_OFS);
                r.payload_size = hdr_word(p2pd_pkg::SIZE_OFS);
                r.checksum = hdr_word(p2pd_pkg::CSUM_OFS);
                hdr_fill = '0;
                bytes_left = r.payload_size;
                if (r.payload_size == 32'd0)
                    r.last_of_message = 1'b1;
                else
                    frame_in_payload = 1'b1;
                pending_results.push_back(r);
            end
        end
        if (eob && (frame_in_payload || hdr_fill != 0))
        begin
            pending_results.push_back(trunc_result());
            frame_in_payload = 1'b0;
            hdr_fill = '0;
            bytes_left = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d", out_if.kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, out_if.kind);
                check_field("magic", want.magic, out_if.magic);
                check_field("command_low", want.command_low, out_if.command_low);
                check_field("command_high", want.command_high, out_if.command_high);
                check_field("payload_size", want.payload_size, out_if.payload_size);
                check_field("checksum", want.checksum, out_if.checksum);
                check_field("payload_byte", want.payload_byte, out_if.payload_byte);
                check_field("last_of_message", want.last_of_message,
                            out_if.last_of_message);
            end
        end
    end

    // offer one item in bursts with random gaps; predict on acceptance
    task automatic send_item(input logic [7:0] b, input logic eob, input row_check_t check);
        int gap;
        int n0;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        in_if.end_of_buffer <= eob;
        do @(posedge clk); while (!in_if.ready);
        n0 = pending_results.size();
        deframe_byte(b, eob);
        if (check != EXP_MODEL)
        begin
            while (pending_results.size() > n0)
                void'(pending_results.pop_back());
            if (check == EXP_TRUNC)
                pending_results.push_back(trunc_result());
        end
        items_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // one well-formed message (possibly cut by a buffer end) or a burst of noise
    task automatic send_message();
        logic [7:0]  hdr [p2pd_pkg::HDR_LEN];
        logic [31:0] size;
        longint      total;
        longint      eob_at;
        longint      i;
        int          pick;
        int          n;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
                send_item(8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0), EXP_MODEL);
        end
        else
        begin
            for (int k = 0; k < p2pd_pkg::HDR_LEN; k++)
            begin
                pick = $urandom_range(0, 7);
                hdr[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            end
            pick = $urandom_range(0, 9);
            if (pick < 2)
                size = 32'd0;
            else if (pick < 8)
                size = $urandom_range(1, 6);
            else if (pick == 8)
                size = $urandom_range(7, 24);
            else
                size = $urandom;
            {hdr[p2pd_pkg::SIZE_OFS + 3], hdr[p2pd_pkg::SIZE_OFS + 2],
             hdr[p2pd_pkg::SIZE_OFS + 1], hdr[p2pd_pkg::SIZE_OFS]} = size;
            total = p2pd_pkg::HDR_LEN + longint'(size);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                eob_at = -1;
            else if (pick < 6)
                eob_at = total - 1;
            else if (pick == 7)
                eob_at = $urandom_range(0, p2pd_pkg::HDR_LEN - 2);
            else if (pick == 8 && size > 1)
                eob_at = p2pd_pkg::HDR_LEN + $urandom_range(0, (size > 24 ? 22 : size - 2));
            else
                eob_at = p2pd_pkg::HDR_LEN - 1;
            if (size > 24 && (eob_at < 0 || eob_at >= total - 1))
                eob_at = p2pd_pkg::HDR_LEN - 1 + $urandom_range(0, 3);
            for (i = 0; i < total && (eob_at < 0 || i <= eob_at); i++)
                send_item((i < p2pd_pkg::HDR_LEN) ? hdr[i] : 8'($urandom), i == eob_at,
                          EXP_MODEL);
        end
    endtask

    // receiver: phases of its own stall pattern, one long hold-off
    initial
    begin
        int  mode;
        int  phase_len;
        bit  held;
        held = 1'b0;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            phase_len = $urandom_range(5, 40);
            for (int k = 0; k < phase_len; k++)
            begin
                @(negedge clk);
                if (!held && items_sent >= HOLD_AT)
                begin
                    held = 1'b1;
                    out_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= (k % 4 == 0);
                    default: out_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial
    begin
        bit paused;
        paused = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.end_of_buffer = 1'b0;
        frame_in_payload = 1'b0;
        hdr_fill = '0;
        bytes_left = '0;
        foreach (hdr_buf[k])
            hdr_buf[k] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[k])
            send_item(DIRECTED_ROWS[k].data_byte, DIRECTED_ROWS[k].end_of_buffer,
                      DIRECTED_ROWS[k].check);

        while (items_sent < $size(DIRECTED_ROWS) + RANDOM_ITEMS)
        begin
            send_message();
            if (!paused && items_sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("p2p_message_deframer test passed");
        else
            $display("p2p_message_deframer test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("p2p_message_deframer test failed");
        $finish;
    end

endmodule
